// ----- rtl/core/qrm_pkg.sv -----
// qrm_pkg: shared constants and types for the quaternion to rotation matrix block
// no dependencies
`default_nettype none

package qrm_pkg;

	localparam int NUM_ENT = 9;

	typedef logic [3:0] ent_idx_t;

	localparam ent_idx_t ENT_M00 = 4'd0;
	localparam ent_idx_t ENT_M11 = 4'd4;
	localparam ent_idx_t ENT_M22 = 4'd8;

endpackage

`default_nettype wire

// ----- rtl/core/quaternion_to_rotation_matrix.sv -----
// Quaternion to 3x3 rotation matrix: takes a quaternion (w, x, y, z) of signed integers at any
// common scale, normalizes it and gives the nine matrix entries in Q2.FRAC_BITS.
// Uses qrm_pkg.
//
// One quaternion is taken per clock, and one result per clock is sustained, while the result
// side does not stall. The pipeline has FRAC_BITS + 6 register stages. In its divider each of
// the nine entries is a ratio to the sum of squares, resolved one quotient bit per pipeline
// stage over FRAC_BITS + 2 stages. In front of the divider sit one multiply stage, one sum
// stage and one sign stage, and the output register follows it. Entries are rounded to
// nearest (ties away from zero) and clamped to +-1.0. An all-zero quaternion gives the
// identity and raises zero_norm. A stall on the result side while a result is offered
// freezes the whole pipeline and is passed back to the request side in the same cycle.
`default_nettype none

module quaternion_to_rotation_matrix #(
	parameter int IN_WIDTH  = 16,
	parameter int FRAC_BITS = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic signed [IN_WIDTH-1:0]    comp_w,
	input  wire logic signed [IN_WIDTH-1:0]    comp_x,
	input  wire logic signed [IN_WIDTH-1:0]    comp_y,
	input  wire logic signed [IN_WIDTH-1:0]    comp_z,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic signed [FRAC_BITS+1:0]        m00,
	output logic signed [FRAC_BITS+1:0]        m01,
	output logic signed [FRAC_BITS+1:0]        m02,
	output logic signed [FRAC_BITS+1:0]        m10,
	output logic signed [FRAC_BITS+1:0]        m11,
	output logic signed [FRAC_BITS+1:0]        m12,
	output logic signed [FRAC_BITS+1:0]        m20,
	output logic signed [FRAC_BITS+1:0]        m21,
	output logic signed [FRAC_BITS+1:0]        m22,
	output logic                               zero_norm
);

	localparam int PW  = 2 * IN_WIDTH;
	localparam int NW  = PW + 2;
	localparam int QB  = FRAC_BITS + 2;
	localparam int NST = FRAC_BITS + 2;
	localparam int OW  = FRAC_BITS + 2;
	localparam int NE  = qrm_pkg::NUM_ENT;

	localparam logic [FRAC_BITS:0] ONE_MAG = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic signed [OW-1:0] ONE_OUT = OW'(1) << FRAC_BITS;
	localparam logic signed [IN_WIDTH-1:0] LOWEST = IN_WIDTH'(1) << (IN_WIDTH - 1);

	logic ce;

	assign ce        = !(rsp_valid && rsp_stall);
	assign req_stall = !ce;

	// stage 1: products
	logic                   lowest_all;
	logic                   zero_in;
	logic signed [IN_WIDTH-1:0] w_c, x_c, y_c, z_c;

	assign lowest_all = (comp_w == LOWEST) && (comp_x == LOWEST) &&
	                    (comp_y == LOWEST) && (comp_z == LOWEST);
	assign zero_in    = (comp_w == '0) && (comp_x == '0) && (comp_y == '0) && (comp_z == '0);
	assign w_c = lowest_all ? '1 : comp_w;
	assign x_c = lowest_all ? '1 : comp_x;
	assign y_c = lowest_all ? '1 : comp_y;
	assign z_c = lowest_all ? '1 : comp_z;

	logic                 valid_s1;
	logic                 zero_s1;
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0] xy_s1, zw_s1, xz_s1, yw_s1, yz_s1, xw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s1 <= zero_in;
			ww_s1   <= PW'(w_c) * PW'(w_c);
			xx_s1   <= PW'(x_c) * PW'(x_c);
			yy_s1   <= PW'(y_c) * PW'(y_c);
			zz_s1   <= PW'(z_c) * PW'(z_c);
			xy_s1   <= PW'(x_c) * PW'(y_c);
			zw_s1   <= PW'(z_c) * PW'(w_c);
			xz_s1   <= PW'(x_c) * PW'(z_c);
			yw_s1   <= PW'(y_c) * PW'(w_c);
			yz_s1   <= PW'(y_c) * PW'(z_c);
			xw_s1   <= PW'(x_c) * PW'(w_c);
		end
	end

	// stage 2: norm and numerators
	logic signed [NW-1:0] ww_e, xx_e, yy_e, zz_e, xy_e, zw_e, xz_e, yw_e, yz_e, xw_e;
	logic signed [NW-1:0] num_c [NE];
	logic        [NW-1:0] norm_c;

	always_comb begin
		ww_e = NW'(ww_s1);
		xx_e = NW'(xx_s1);
		yy_e = NW'(yy_s1);
		zz_e = NW'(zz_s1);
		xy_e = NW'(xy_s1);
		zw_e = NW'(zw_s1);
		xz_e = NW'(xz_s1);
		yw_e = NW'(yw_s1);
		yz_e = NW'(yz_s1);
		xw_e = NW'(xw_s1);
		norm_c   = $unsigned(ww_e + xx_e + yy_e + zz_e);
		num_c[0] = (ww_e + xx_e) - (yy_e + zz_e);
		num_c[1] = (xy_e - zw_e) <<< 1;
		num_c[2] = (xz_e + yw_e) <<< 1;
		num_c[3] = (xy_e + zw_e) <<< 1;
		num_c[4] = (ww_e + yy_e) - (xx_e + zz_e);
		num_c[5] = (yz_e - xw_e) <<< 1;
		num_c[6] = (xz_e - yw_e) <<< 1;
		num_c[7] = (yz_e + xw_e) <<< 1;
		num_c[8] = (ww_e + zz_e) - (xx_e + yy_e);
	end

	logic                 valid_s2;
	logic                 zero_s2;
	logic        [NW-1:0] norm_s2;
	logic signed [NW-1:0] num_s2 [NE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s2 <= zero_s1;
			norm_s2 <= norm_c;
			for (int k = 0; k < NE; k++) begin
				num_s2[k] <= num_c[k];
			end
		end
	end

	// stage 3: sign and magnitude
	logic          valid_s3;
	logic          zero_s3;
	logic [NW-1:0] norm_s3;
	logic          neg_s3 [NE];
	logic [NW-1:0] mag_s3 [NE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s3 <= zero_s2;
			norm_s3 <= norm_s2;
			for (int k = 0; k < NE; k++) begin
				neg_s3[k] <= num_s2[k][NW-1];
				mag_s3[k] <= num_s2[k][NW-1] ? $unsigned(-num_s2[k]) : $unsigned(num_s2[k]);
			end
		end
	end

	// stage 4: restoring divider, one quotient bit per stage
	logic          valid_s4 [NST];
	logic          zero_s4  [NST];
	logic [NW-1:0] norm_s4  [NST];
	logic          neg_s4   [NST][NE];
	logic [NW-1:0] rem_s4   [NST][NE];
	logic [QB-1:0] quo_s4   [NST][NE];

	for (genvar j = 0; j < NST; j++) begin : g_div
		if (j == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s4[j] <= 1'b0;
				end else if (ce) begin
					valid_s4[j] <= valid_s3;
				end
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					zero_s4[j] <= zero_s3;
					norm_s4[j] <= norm_s3;
					for (int k = 0; k < NE; k++) begin
						neg_s4[j][k] <= neg_s3[k];
						if (mag_s3[k] >= norm_s3) begin
							rem_s4[j][k] <= mag_s3[k] - norm_s3;
							quo_s4[j][k] <= QB'(1);
						end else begin
							rem_s4[j][k] <= mag_s3[k];
							quo_s4[j][k] <= '0;
						end
					end
				end
			end
		end else begin : g_step
			logic [NW:0] dbl [NE];
			logic [NW:0] nrm_e;

			always_comb begin
				nrm_e = (NW+1)'(norm_s4[j-1]);
				for (int k = 0; k < NE; k++) begin
					dbl[k] = {rem_s4[j-1][k], 1'b0};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s4[j] <= 1'b0;
				end else if (ce) begin
					valid_s4[j] <= valid_s4[j-1];
				end
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					zero_s4[j] <= zero_s4[j-1];
					norm_s4[j] <= norm_s4[j-1];
					for (int k = 0; k < NE; k++) begin
						neg_s4[j][k] <= neg_s4[j-1][k];
						if (dbl[k] >= nrm_e) begin
							rem_s4[j][k] <= NW'(dbl[k] - nrm_e);
							quo_s4[j][k] <= {quo_s4[j-1][k][QB-2:0], 1'b1};
						end else begin
							rem_s4[j][k] <= dbl[k][NW-1:0];
							quo_s4[j][k] <= {quo_s4[j-1][k][QB-2:0], 1'b0};
						end
					end
				end
			end
		end
	end

	// stage 5: round, clamp, sign, identity override
	logic [QB-1:0]        rnd_c [NE];
	logic [FRAC_BITS:0]   sat_c [NE];
	logic signed [OW-1:0] ent_c [NE];

	always_comb begin
		for (int k = 0; k < NE; k++) begin
			rnd_c[k] = (quo_s4[NST-1][k] + QB'(1)) >> 1;
			sat_c[k] = (rnd_c[k] > QB'(ONE_MAG)) ? ONE_MAG : rnd_c[k][FRAC_BITS:0];
			if (zero_s4[NST-1]) begin
				if (qrm_pkg::ent_idx_t'(k) == qrm_pkg::ENT_M00 ||
				    qrm_pkg::ent_idx_t'(k) == qrm_pkg::ENT_M11 ||
				    qrm_pkg::ent_idx_t'(k) == qrm_pkg::ENT_M22) begin
					ent_c[k] = ONE_OUT;
				end else begin
					ent_c[k] = '0;
				end
			end else if (neg_s4[NST-1][k]) begin
				ent_c[k] = -$signed(OW'(sat_c[k]));
			end else begin
				ent_c[k] = $signed(OW'(sat_c[k]));
			end
		end
	end

	logic                 valid_s5;
	logic                 zero_s5;
	logic signed [OW-1:0] ent_s5 [NE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ce) begin
			valid_s5 <= valid_s4[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s5 <= zero_s4[NST-1];
			for (int k = 0; k < NE; k++) begin
				ent_s5[k] <= ent_c[k];
			end
		end
	end

	assign rsp_valid = valid_s5;
	assign zero_norm = zero_s5;
	assign m00 = ent_s5[0];
	assign m01 = ent_s5[1];
	assign m02 = ent_s5[2];
	assign m10 = ent_s5[3];
	assign m11 = ent_s5[4];
	assign m12 = ent_s5[5];
	assign m20 = ent_s5[6];
	assign m21 = ent_s5[7];
	assign m22 = ent_s5[8];

	// checks
	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && zero_norm |-> m00 == ONE_OUT && m11 == ONE_OUT && m01 == '0)
		else $error("zero quaternion did not give identity");

	a_diag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> m00 <= ONE_OUT && m00 >= -ONE_OUT && m22 <= ONE_OUT && m22 >= -ONE_OUT)
		else $error("diagonal entry beyond unit range");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held result");

endmodule

`default_nettype wire

// ----- tb/quaternion_to_rotation_matrix_checker.sv -----
// checker for quaternion_to_rotation_matrix: watches both channels, predicts each matrix
// from the accepted quaternion and compares it field by field against the result transfers
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_stall,
	input  wire logic signed [15:0] comp_w,
	input  wire logic signed [15:0] comp_x,
	input  wire logic signed [15:0] comp_y,
	input  wire logic signed [15:0] comp_z,
	input  wire logic               rsp_valid,
	input  wire logic               rsp_stall,
	input  wire logic signed [15:0] m00,
	input  wire logic signed [15:0] m01,
	input  wire logic signed [15:0] m02,
	input  wire logic signed [15:0] m10,
	input  wire logic signed [15:0] m11,
	input  wire logic signed [15:0] m12,
	input  wire logic signed [15:0] m20,
	input  wire logic signed [15:0] m21,
	input  wire logic signed [15:0] m22,
	input  wire logic               zero_norm,
	output int                      errors,
	output int                      pending
);

	localparam int FRAC = 14;

	typedef struct packed {
		logic [8:0][15:0] ent;
		logic             zn;
	} matrix_t;

	matrix_t expected_matrices[$];

	// round(a * 2^k / n), ties away from zero
	function automatic longint unsigned div_round(longint unsigned a, longint unsigned n, int k);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = a;
		if (r >= n) begin
			q = 1;
			r -= n;
		end
		for (int i = 0; i < k + 1; i++) begin
			q <<= 1;
			if (r >= n - r) begin
				r = r - (n - r);
				q |= 1;
			end else begin
				r += r;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic logic [15:0] signed_entry(bit neg, longint unsigned mag);
		if (mag > (64'd1 << FRAC))
			mag = 64'd1 << FRAC;
		return neg ? 16'(-mag) : 16'(mag);
	endfunction

	function automatic logic [15:0] cross_term(longint d, longint unsigned n);
		longint unsigned m;
		m = d < 0 ? longint'(-d) : d;
		return signed_entry(d < 0, div_round(m, n, FRAC + 1));
	endfunction

	function automatic logic [15:0] diag_term(longint unsigned p, longint unsigned q,
			longint unsigned n);
		if (p >= q)
			return signed_entry(0, div_round(p - q, n, FRAC));
		return signed_entry(1, div_round(q - p, n, FRAC));
	endfunction

	function automatic matrix_t rotation_of(longint w, longint x, longint y, longint z);
		matrix_t r;
		longint unsigned ww, xx, yy, zz, n;
		r = '0;
		if (w == 0 && x == 0 && y == 0 && z == 0) begin
			r.ent[0] = 16'd1 << FRAC;
			r.ent[4] = 16'd1 << FRAC;
			r.ent[8] = 16'd1 << FRAC;
			r.zn = 1;
			return r;
		end
		if (w == -32768 && x == -32768 && y == -32768 && z == -32768) begin
			w = -1; x = -1; y = -1; z = -1;
		end
		ww = w * w; xx = x * x; yy = y * y; zz = z * z;
		n = ww + xx + yy + zz;
		r.ent[0] = diag_term(ww + xx, yy + zz, n);
		r.ent[1] = cross_term(x * y - z * w, n);
		r.ent[2] = cross_term(x * z + y * w, n);
		r.ent[3] = cross_term(x * y + z * w, n);
		r.ent[4] = diag_term(ww + yy, xx + zz, n);
		r.ent[5] = cross_term(y * z - x * w, n);
		r.ent[6] = cross_term(x * z - y * w, n);
		r.ent[7] = cross_term(y * z + x * w, n);
		r.ent[8] = diag_term(ww + zz, xx + yy, n);
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		matrix_t got;
		matrix_t want;
		if (arst_n && req_valid && !req_stall)
			expected_matrices.push_back(rotation_of(comp_w, comp_x, comp_y, comp_z));
		if (arst_n && rsp_valid && !rsp_stall) begin
			got.ent = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
			got.zn = zero_norm;
			if (expected_matrices.size() == 0) begin
				$display("%0t: unexpected transfer, expected none actual %h", $time, got);
				errors++;
			end else begin
				want = expected_matrices.pop_front();
				for (int i = 0; i < 9; i++)
					if (got.ent[i] !== want.ent[i]) begin
						$display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
							$signed(want.ent[i]), $signed(got.ent[i]));
						errors++;
					end
				if (got.zn !== want.zn) begin
					$display("%0t: zero_norm expected %b actual %b", $time, want.zn, got.zn);
					errors++;
				end
			end
		end
		pending = expected_matrices.size();
	end

endmodule

// ----- tb/quaternion_to_rotation_matrix_test.sv -----
// top of the quaternion_to_rotation_matrix testbench: clock, reset, quaternion stimulus,
// result-side stalls and verdict; depends on the block and quaternion_to_rotation_matrix_checker
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_test;

	localparam int LATENCY = 21;
	localparam int WATCHDOG = 5000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic signed [15:0] comp_w, comp_x, comp_y, comp_z;
	logic rsp_valid;
	logic rsp_stall;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic zero_norm;
	int errors;
	int pending;
	bit calm;
	bit hold_off;
	int idle_cycles;

	quaternion_to_rotation_matrix uut (.*);
	quaternion_to_rotation_matrix_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// result-side stalls in bursts, a long hold-off on request
	always @(negedge clk) begin
		int burst;
		if (hold_off) begin
			rsp_stall <= 1'b1;
			repeat (300) @(negedge clk);
			rsp_stall <= 1'b0;
			hold_off = 0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 16);
			rsp_stall <= 1'b1;
			repeat (burst) @(negedge clk);
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req_valid <= 1'b1;
		comp_w <= w;
		comp_x <= x;
		comp_y <= y;
		comp_z <= z;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_comp(int mode);
		case (mode)
			0: return 16'($urandom_range(0, 7)) - 16'd3;
			1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] c[4];
		int mode;
		calm = 0;
		hold_off = 0;
		idle_cycles = 0;
		req_valid = 1'b0;
		rsp_stall = 1'b0;
		comp_w = '0;
		comp_x = '0;
		comp_y = '0;
		comp_z = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		// zero, extremes, most negative on all four, axes and ties
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000);
		send_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000);
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
		send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000);
		send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
		send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h0001);
		send_quat(16'h0001, 16'h0002, 16'h0003, 16'h0004);
		send_quat(16'h5555, 16'haaaa, 16'h1234, 16'hedcb);
		// long hold-off while offering items
		hold_off = 1;
		for (int i = 0; i < 60; i++)
			send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		req_valid <= 1'b0;
		// pause until drained
		while (pending != 0)
			@(negedge clk);
		for (int i = 0; i < 1400; i++) begin
			if (i == 1200)
				calm = 1;
			mode = $urandom_range(0, 9);
			mode = mode < 2 ? 0 : (mode < 3 ? 1 : 2);
			foreach (c[k])
				c[k] = rand_comp(mode);
			if ($urandom_range(0, 30) == 0)
				c = '{16'h0, 16'h0, 16'h0, 16'h0};
			send_quat(c[0], c[1], c[2], c[3]);
		end
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/qrm_pkg.sv
rtl/core/quaternion_to_rotation_matrix.sv
tb/quaternion_to_rotation_matrix_checker.sv
tb/quaternion_to_rotation_matrix_test.sv
